// ----- rtl/u2a_pkg.sv -----
`timescale 1ns / 1ps
package u2a_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CHAR_W = 7;
    localparam int REM_W  = 2;

    localparam logic [CHAR_W-1:0] ASC_SPACE  = 7'h20;
    localparam logic [CHAR_W-1:0] ASC_APOS   = 7'h27;
    localparam logic [CHAR_W-1:0] ASC_DQUOTE = 7'h22;
    localparam logic [CHAR_W-1:0] ASC_DASH   = 7'h2D;
    localparam logic [CHAR_W-1:0] ASC_STAR   = 7'h2A;
    localparam logic [CHAR_W-1:0] ASC_DOT    = 7'h2E;
    localparam logic [CHAR_W-1:0] ASC_UPPER_O = 7'h4F;
    localparam logic [CHAR_W-1:0] ASC_LOWER_O = 7'h6F;
    localparam logic [CHAR_W-1:0] ASC_UPPER_S = 7'h53;
    localparam logic [CHAR_W-1:0] ASC_LOWER_S = 7'h73;
    localparam logic [CHAR_W-1:0] ASC_UPPER_Z = 7'h5A;
    localparam logic [CHAR_W-1:0] ASC_LOWER_Z = 7'h7A;

    // base letters for U+00C0 .. U+00FF
    localparam logic [0:63][7:0] LATIN1_FOLD =
        "AAAAAAACEEEEIIIIDNOOOOO*OUUUUYPsaaaaaaaceeeeiiiidnooooo/ouuuuypy";

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [CP_W-1:0]  cp;
    } t_dec_state;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] ch;
    } t_fold_res;

    function automatic t_fold_res fold_cp(input logic [CP_W-1:0] cp);
        t_fold_res r;
        r.hit = 1'b1;
        r.ch  = '0;
        if (cp < 21'h80) begin
            r.ch = cp[CHAR_W-1:0];
        end else begin
            case (cp)
                21'h00A0: r.ch = ASC_SPACE;
                21'h2018, 21'h2019, 21'h201A, 21'h2032: r.ch = ASC_APOS;
                21'h201C, 21'h201D, 21'h201E, 21'h2033: r.ch = ASC_DQUOTE;
                21'h2013, 21'h2014, 21'h2212, 21'h2010, 21'h2011: r.ch = ASC_DASH;
                21'h2022, 21'h00B7, 21'h25AA, 21'h2023: r.ch = ASC_STAR;
                21'h2026: r.ch = ASC_DOT;
                21'h0152: r.ch = ASC_UPPER_O;
                21'h0153: r.ch = ASC_LOWER_O;
                21'h0160, 21'h015A: r.ch = ASC_UPPER_S;
                21'h0161, 21'h015B: r.ch = ASC_LOWER_S;
                21'h017D, 21'h0179: r.ch = ASC_UPPER_Z;
                21'h017E, 21'h017A: r.ch = ASC_LOWER_Z;
                default: begin
                    if (cp >= 21'h00C0 && cp <= 21'h00FF) begin
                        r.ch = LATIN1_FOLD[cp[5:0]][CHAR_W-1:0];
                    end else begin
                        r.hit = 1'b0;
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/utf8_to_ascii_fold_unit.sv -----
`timescale 1ns / 1ps
// UTF-8 to ASCII folding stream unit. One byte enters per cycle on s_axis; each complete code
// point with an ASCII form passes the input register and the result register and leaves as
// one character on m_axis; bytes that complete nothing or fold to nothing give no output. The
// input register, the decode and fold logic and the result register form a two-stage pipeline,
// so throughput is one byte per cycle while no stall holds it; s_axis_tready drops only while
// the result register holds an undelivered character and m_axis_tready is low.
module utf8_to_ascii_fold_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [6:0] ascii_char, [7] zero
);
    import u2a_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    t_dec_state        r_state;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;

    t_dec_state        n_state;
    t_fold_res         w_res;
    logic              w_adv;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    u2a_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (r_in_valid && w_adv) begin
                r_state <= n_state;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && w_res.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_adv && r_in_valid && w_res.hit) begin
            r_out_char <= w_res.ch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};

endmodule

// ----- rtl/u2a_decode.sv -----
`timescale 1ns / 1ps
module u2a_decode (
    input  u2a_pkg::t_dec_state i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output u2a_pkg::t_dec_state o_state,
    output u2a_pkg::t_fold_res  o_res
);
    import u2a_pkg::*;

    logic             w_cont;
    logic             w_cp_valid;
    logic [CP_W-1:0]  w_cp;
    logic [CP_W-1:0]  w_shifted;
    logic [REM_W-1:0] w_rem_dec;
    t_dec_state       w_next;
    t_fold_res        w_fold;

    assign w_cont    = (i_state.rem != '0) && (i_byte[7:6] == 2'b10);
    assign w_shifted = {i_state.cp[CP_W-7:0], i_byte[5:0]};
    assign w_rem_dec = i_state.rem - 2'd1;

    always_comb begin
        w_next     = '0;
        w_cp_valid = 1'b0;
        w_cp       = '0;
        if (w_cont) begin
            w_next.rem = w_rem_dec;
            w_next.cp  = w_shifted;
            if (w_rem_dec == '0) begin
                w_cp_valid = 1'b1;
                w_cp       = w_shifted;
                w_next.cp  = '0;
            end
        end else if (!i_byte[7]) begin
            w_cp_valid = 1'b1;
            w_cp       = {{(CP_W-BYTE_W){1'b0}}, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            w_next.rem = 2'd1;
            w_next.cp  = {{(CP_W-5){1'b0}}, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            w_next.rem = 2'd2;
            w_next.cp  = {{(CP_W-4){1'b0}}, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            w_next.rem = 2'd3;
            w_next.cp  = {{(CP_W-3){1'b0}}, i_byte[2:0]};
        end
        // end of stream closes any open sequence
        if (i_last) begin
            w_next = '0;
        end
    end

    assign w_fold      = fold_cp(w_cp);
    assign o_state     = w_next;
    assign o_res.hit   = w_cp_valid && w_fold.hit;
    assign o_res.ch    = w_fold.ch;

endmodule

// ----- rtl/u2a_checker.sv -----
`timescale 1ns / 1ps
module u2a_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // output is always plain ascii
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("non-ascii result");

    // empty result register never blocks a request
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_to_ascii_fold_unit u2a_checker u_chk (.*);

// ----- dv/ascii_fold_monitor.sv -----
`timescale 1ns / 1ps
module ascii_fold_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_stream
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output int         o_fail_count,
    output int         o_pending
);

    // base letters for U+00C0 .. U+00FF
    localparam logic [0:63][7:0] ACCENT_BASE =
        "AAAAAAACEEEEIIIIDNOOOOO*OUUUUYPsaaaaaaaceeeeiiiidnooooo/ouuuuypy";

    logic [1:0]  seq_left;
    logic [20:0] seq_cp;
    logic [6:0]  ascii_due[$];
    logic [6:0]  want;
    int          done_cp;
    int          folded;
    int          mismatches = 0;
    int          printed = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what);
        mismatches = mismatches + 1;
        if (printed < 100) begin
            printed = printed + 1;
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    // -1 when the code point has no ascii form
    function automatic int fold_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            return int'(cp);
        end
        case (cp)
            21'h00A0: return 'h20;
            21'h2018, 21'h2019, 21'h201A, 21'h2032: return 'h27;
            21'h201C, 21'h201D, 21'h201E, 21'h2033: return 'h22;
            21'h2010, 21'h2011, 21'h2013, 21'h2014, 21'h2212: return 'h2D;
            21'h00B7, 21'h2022, 21'h2023, 21'h25AA: return 'h2A;
            21'h2026: return 'h2E;
            21'h0152: return 'h4F;
            21'h0153: return 'h6F;
            21'h015A, 21'h0160: return 'h53;
            21'h015B, 21'h0161: return 'h73;
            21'h0179, 21'h017D: return 'h5A;
            21'h017A, 21'h017E: return 'h7A;
            default: ;
        endcase
        if (cp >= 21'h00C0 && cp <= 21'h00FF) begin
            return int'(ACCENT_BASE[cp[5:0]][6:0]);
        end
        return -1;
    endfunction

    // advances the decoder by one byte, cp is -1 unless a code point completes
    task automatic decode_byte(input logic [7:0] b, input logic eos, output int cp);
        cp = -1;
        if (seq_left != 2'd0 && b[7:6] == 2'b10) begin
            seq_cp   = {seq_cp[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
                cp     = int'(seq_cp);
                seq_cp = '0;
            end
        end else begin
            seq_left = '0;
            seq_cp   = '0;
            if (!b[7]) begin
                cp = int'(b);
            end else if (b[7:5] == 3'b110) begin
                seq_left = 2'd1;
                seq_cp   = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_left = 2'd2;
                seq_cp   = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                seq_left = 2'd3;
                seq_cp   = {18'd0, b[2:0]};
            end
        end
        if (eos) begin
            seq_left = '0;
            seq_cp   = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_left = '0;
            seq_cp   = '0;
            ascii_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (ascii_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h", m_axis_tdata));
                end else begin
                    want = ascii_due.pop_front();
                    if (m_axis_tdata[6:0] !== want) begin
                        report_mismatch($sformatf("char 0x%02h, wanted 0x%02h",
                                                  m_axis_tdata[6:0], want));
                    end
                    if (m_axis_tdata[7] !== 1'b0) begin
                        report_mismatch("padding bit of tdata not zero");
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast, done_cp);
                if (done_cp >= 0) begin
                    folded = fold_point(done_cp[20:0]);
                    if (folded >= 0) begin
                        ascii_due.push_back(folded[6:0]);
                    end
                end
            end
        end
        o_pending <= ascii_due.size();
    end

endmodule

// ----- dv/utf8_to_ascii_fold_unit_test.sv -----
`timescale 1ns / 1ps
module utf8_to_ascii_fold_unit_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int BYTE_TARGET = 2000;

    localparam logic [20:0] FOLD_POINTS [30] = '{
        21'h00A0, 21'h2018, 21'h2019, 21'h201A, 21'h2032, 21'h201C, 21'h201D, 21'h201E,
        21'h2033, 21'h2013, 21'h2014, 21'h2212, 21'h2010, 21'h2011, 21'h2022, 21'h00B7,
        21'h25AA, 21'h2023, 21'h2026, 21'h0152, 21'h0153, 21'h0160, 21'h015A, 21'h0161,
        21'h015B, 21'h017D, 21'h0179, 21'h017E, 21'h017A, 21'h25AB
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       s_axis_tlast;   // end_of_stream
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [6:0] ascii_char, [7] zero

    int fail_count;
    int pending;
    int rx_hold = 0;
    int cycle_cnt;
    bit steady;

    utf8_to_ascii_fold_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ascii_fold_monitor i_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt = cycle_cnt + 1;
        end
        $display("Regression FAIL");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int min_len(input logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [20:0] pick_cp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return FOLD_POINTS[$urandom_range(0, 29)];
        if (r < 50) return 21'($urandom_range('hC0, 'hFF));
        if (r < 65) return 21'($urandom_range('h80, 'hBF));
        if (r < 80) return 21'($urandom_range('h100, 'h17F));
        if (r < 90) return 21'($urandom_range('h2000, 'h2040));
        return 21'($urandom_range(0, 'h1FFFFF));
    endfunction

    // rising edge only; tvalid stays high across back-to-back requests
    task automatic push_byte(input logic [7:0] b, input logic eos);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // encodes cp in len bytes and sends the first cut of them
    task automatic send_cp(input logic [20:0] cp, input int len, input int cut,
                           input bit eos_end);
        logic [7:0] seq [4];
        logic       eos;
        case (len)
            1: begin
                seq[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < cut; i++) begin
            eos = (i == cut - 1) ? eos_end : ($urandom_range(0, 99) == 0);
            push_byte(seq[i], eos);
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end else if (steady || $urandom_range(0, 99) < 60) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold       <= pick_gap();
        end
    end

    initial begin
        int          sent;
        int          r;
        int          len;
        int          cut;
        logic [20:0] cp;

        steady        <= 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ascii extremes, folds, unmapped, stray, invalid, broken, eos, overlong
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        send_cp(21'h00A0, 2, 2, 1'b0);
        send_cp(21'h2019, 3, 3, 1'b0);
        send_cp(21'h1F600, 4, 4, 1'b0);
        send_cp(21'h00FF, 2, 2, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h41, 1'b0);
        send_cp(21'h2026, 3, 2, 1'b1);
        send_cp(21'h0000, 2, 2, 1'b0);
        send_cp(21'h017D, 2, 2, 1'b0);
        push_byte(8'h7A, 1'b1);

        sent = 0;
        while (sent < BYTE_TARGET) begin
            if ($urandom_range(0, 149) == 0) begin
                steady <= !steady;
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                cp  = pick_cp();
                len = min_len(cp);
                if (len < 4 && $urandom_range(0, 9) == 0) begin
                    len = $urandom_range(len + 1, 4);
                end
                send_cp(cp, len, len, $urandom_range(0, 19) == 0);
                sent += len;
            end else if (r < 60) begin
                push_byte({1'b0, 7'($urandom)}, $urandom_range(0, 19) == 0);
                sent += 1;
            end else if (r < 72) begin
                push_byte(8'($urandom), 1'($urandom));
                sent += 1;
            end else if (r < 84) begin
                cp  = pick_cp();
                len = min_len(cp);
                if (len < 2) len = 2;
                cut = $urandom_range(1, len - 1);
                send_cp(cp, len, cut, $urandom_range(0, 3) == 0);
                sent += cut;
            end else if (r < 92) begin
                push_byte(8'($urandom_range('hF8, 'hFF)), $urandom_range(0, 9) == 0);
                sent += 1;
            end else begin
                push_byte(8'($urandom_range('h80, 'hBF)), $urandom_range(0, 9) == 0);
                sent += 1;
            end
        end

        s_axis_tvalid <= 1'b0;
        steady        <= 1'b1;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
